[hw/rtl/hcbp_pkg.sv]
`default_nettype none

package hcbp_pkg;

   localparam int unsigned MAX_CODE_LEN_DEF = 32;

   localparam int unsigned OP_W        = 2;
   localparam int unsigned SYM_W       = 8;
   localparam int unsigned CODE_BITS_W = 32;
   localparam int unsigned CODE_LEN_W  = 6;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned MAX_BYTES   = 4;
   localparam int unsigned BYTE_CNT_W  = 3;
   localparam int unsigned ACC_W       = 7;
   localparam int unsigned PEND_W      = 3;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]        operation;
      logic [SYM_W-1:0]       symbol;
      logic [CODE_BITS_W-1:0] code_bits;
      logic [CODE_LEN_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

   // bytes[0] leaves first
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [BYTE_CNT_W-1:0]            count;
   } byte_grp_type;

endpackage

`default_nettype wire

[hw/rtl/hcbp_code_table.sv]
`default_nettype none

module hcbp_code_table #(
   parameter int unsigned LEN_CAP = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic                             rd_en,
   input  logic [hcbp_pkg::SYM_W-1:0]       addr,
   input  logic [hcbp_pkg::CODE_BITS_W-1:0] wr_code,
   input  logic [hcbp_pkg::CODE_LEN_W-1:0]  wr_len,
   output logic [hcbp_pkg::CODE_BITS_W-1:0] rd_code,
   output logic [hcbp_pkg::CODE_LEN_W-1:0]  rd_len
);
   import hcbp_pkg::*;

   localparam int unsigned LEN_W = $clog2(LEN_CAP + 1);
   localparam int unsigned DEPTH = 1 << SYM_W;

   logic [LEN_CAP-1:0] code_mem [DEPTH];
   logic [LEN_W-1:0]   len_mem  [DEPTH];
   logic [LEN_CAP-1:0] rd_code_ff;
   logic [LEN_W-1:0]   rd_len_ff;
   logic [LEN_W-1:0]   len_sat;
   logic [LEN_CAP-1:0] code_msk;

   // saturate length, drop pattern bits at or above it
   always_comb begin
      if (wr_len > CODE_LEN_W'(LEN_CAP)) begin
         len_sat = LEN_W'(LEN_CAP);
      end else begin
         len_sat = wr_len[LEN_W-1:0];
      end
      for (int i = 0; i < LEN_CAP; i++) begin
         code_msk[i] = wr_code[i] && (i < int'(len_sat));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem[addr] <= code_msk;
         len_mem[addr]  <= len_sat;
      end
      if (rd_en) begin
         rd_code_ff <= code_mem[addr];
         rd_len_ff  <= len_mem[addr];
      end
   end

   assign rd_code = CODE_BITS_W'(rd_code_ff);
   assign rd_len  = CODE_LEN_W'(rd_len_ff);

endmodule

`default_nettype wire

[hw/rtl/hcbp_packer.sv]
`default_nettype none

module hcbp_packer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [hcbp_pkg::OP_W-1:0]        op,
   input  logic [hcbp_pkg::CODE_BITS_W-1:0] code,
   input  logic [hcbp_pkg::CODE_LEN_W-1:0]  len,
   output hcbp_pkg::byte_grp_type           grp
);
   import hcbp_pkg::*;

   // pending bits plus one full code, rounded up to whole bytes
   localparam int unsigned ALIGN_W = ACC_W + CODE_BITS_W + 1;

   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [PEND_W-1:0]     cnt_ff, cnt_in;
   logic [PEND_W-1:0]     shift_acc;
   logic [CODE_LEN_W-1:0] shift_code;
   logic [CODE_LEN_W-1:0] total;
   logic [ALIGN_W-1:0]    acc_l, code_l, left;
   logic [ACC_W-1:0]      low_bits, keep_mask;

   always_comb begin
      // left-justify pending bits, then the code right behind them
      shift_acc  = PEND_W'(ACC_W) - cnt_ff;
      shift_code = CODE_LEN_W'(CODE_BITS_W) - len;
      acc_l      = {acc_ff, (ALIGN_W - ACC_W)'(0)} << shift_acc;
      code_l     = ({code, (ALIGN_W - CODE_BITS_W)'(0)} << shift_code) >> cnt_ff;
      left       = acc_l | code_l;
      total      = CODE_LEN_W'(cnt_ff) + len;
      // leftover tail, right-aligned
      low_bits   = (acc_ff << len) | code[ACC_W-1:0];
      keep_mask  = ~({ACC_W{1'b1}} << total[PEND_W-1:0]);

      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      grp.count = '0;
      for (int k = 0; k < MAX_BYTES; k++) begin
         grp.bytes[k] = left[ALIGN_W-1-BYTE_W*k -: BYTE_W];
      end

      unique case (op)
         OP_ENCODE: begin
            grp.count = total[CODE_LEN_W-1:PEND_W];
            cnt_in    = total[PEND_W-1:0];
            acc_in    = low_bits & keep_mask;
         end
         OP_FLUSH: begin
            if (cnt_ff != '0) begin
               grp.count    = BYTE_CNT_W'(1);
               grp.bytes[0] = BYTE_W'(acc_ff);
               acc_in       = '0;
               cnt_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/hcbp_out_buf.sv]
`default_nettype none

module hcbp_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  hcbp_pkg::byte_grp_type grp,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output hcbp_pkg::rsp_type      rsp_data,
   output logic                   free
);
   import hcbp_pkg::*;

   logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_ff, bytes_in;
   logic [BYTE_CNT_W-1:0]            cnt_ff, cnt_in;
   logic                             take;

   assign take = (cnt_ff != '0) && !rsp_stall;
   // empty, or last byte leaving this cycle
   assign free = (cnt_ff == '0) || ((cnt_ff == BYTE_CNT_W'(1)) && take);

   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         bytes_in = grp.bytes;
         cnt_in   = grp.count;
      end else if (take) begin
         bytes_in = {BYTE_W'(0), bytes_ff[MAX_BYTES-1:1]};
         cnt_in   = cnt_ff - BYTE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_valid         = (cnt_ff != '0);
   assign rsp_data.out_byte = bytes_ff[0];
   assign rsp_data.last     = (cnt_ff == BYTE_CNT_W'(1));

endmodule

`default_nettype wire

[hw/rtl/huffman_code_bit_packer_unit.sv]
// Huffman code bit packer.
// req channel (req_valid / req_stall / req_data): one beat is one item.
//   LOAD writes a 256-entry code table entry (pattern + length, length
//   saturated to min(MAX_CODE_LEN, 32)); ENCODE appends the symbol's code
//   to the bit accumulator MSB-first; FLUSH emits the 1..7 pending bits as
//   one right-aligned byte. LOAD and unused codes give no output.
// rsp channel (rsp_valid / rsp_stall / rsp_data): one beat per packed byte,
//   last set on the final byte of an item. Items with no bytes give no beat.
// Flow: the table read is registered as an item is accepted into stage A;
//   the item is packed into the output buffer once that buffer is free.
// Rate: the output buffer sends one byte per cycle unless rsp_stall holds
//   it; an item gives 0..4 bytes, and a new item loads as its last byte leaves.
// Reset (synchronous): empties pipeline and buffer, clears pending bits.
//   The code table is not cleared; encoding a never-loaded symbol is
//   undefined.
// rsp_stall holds the current byte; req_stall rises while the input stage
//   holds an item and the buffer still has bytes beyond one leaving now.
`default_nettype none

module huffman_code_bit_packer_unit #(
   parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcbp_pkg::rsp_type rsp_data
);
   import hcbp_pkg::*;

   // effective length bound, never above the 32-bit pattern field
   localparam int unsigned LEN_CAP =
      (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;

   logic                   req_take;
   logic                   a_go;
   logic                   ob_free;
   logic                   a_vld_ff, a_vld_in;
   logic [OP_W-1:0]        a_op_ff;
   logic [CODE_BITS_W-1:0] tbl_code;
   logic [CODE_LEN_W-1:0]  tbl_len;
   byte_grp_type           grp;

   // stage A moves on whenever the output buffer can take its bytes
   assign a_go      = a_vld_ff && ob_free;
   assign req_stall = a_vld_ff && !ob_free;
   assign req_take  = req_valid && !req_stall;
   assign a_vld_in  = req_take || (a_vld_ff && !a_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
      if (req_take) begin
         a_op_ff <= req_data.operation;
      end
   end

   // table: written on LOAD beats, read on every accepted beat;
   // read data holds while stage A waits
   hcbp_code_table #(
      .LEN_CAP (LEN_CAP)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_take && (req_data.operation == OP_LOAD)),
      .rd_en   (req_take),
      .addr    (req_data.symbol),
      .wr_code (req_data.code_bits),
      .wr_len  (req_data.code_length),
      .rd_code (tbl_code),
      .rd_len  (tbl_len)
   );

   // accumulator and byte slicing, one item per a_go
   hcbp_packer u_packer (
      .clock (clock),
      .reset (reset),
      .step  (a_go),
      .op    (a_op_ff),
      .code  (tbl_code),
      .len   (tbl_len),
      .grp   (grp)
   );

   // holds up to four bytes, sends one per cycle unless rsp_stall is high
   hcbp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (a_go),
      .grp       (grp),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (ob_free)
   );

endmodule

`default_nettype wire

[tb/huffman_code_bit_packer_unit_tb.sv]
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_tb;
   import hcbp_pkg::*;

   // op code 3 is not decoded by the block; it must be dropped silently
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // stored lengths saturate at min(MAX_CODE_LEN, 32)
   localparam int unsigned LEN_CAP = (MAX_CODE_LEN_DEF < 32) ? MAX_CODE_LEN_DEF : 32;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   huffman_code_bit_packer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Packer shadow state: code table plus the pending bit accumulator.
   // ------------------------------------------------------------------
   logic [CODE_BITS_W-1:0] sym_code [256];
   logic [CODE_LEN_W-1:0]  sym_len  [256];
   logic [ACC_W-1:0]       acc_bits  = '0;
   logic [PEND_W-1:0]      acc_count = '0;

   req_type pending_items  [$];   // beats waiting to be sent
   rsp_type expected_bytes [$];   // packed bytes still owed by the block
   int      mismatch_count = 0;

   // idle odds in percent; changed per phase by the sequencer
   int unsigned send_idle_pct = 37;
   int unsigned recv_idle_pct = 72;

   // Apply one accepted beat to the shadow state and queue the bytes it owes.
   task automatic pack_code_bytes(input req_type item);
      logic [63:0]  acc;
      logic [63:0]  shifted;
      int unsigned  clen;
      int unsigned  cnt;
      rsp_type      out;
      case (item.operation)
         OP_LOAD: begin
            clen = item.code_length;
            if (clen > LEN_CAP) clen = LEN_CAP;
            sym_code[item.symbol] = item.code_bits;
            sym_len[item.symbol]  = clen[CODE_LEN_W-1:0];
         end
         OP_ENCODE: begin
            clen = sym_len[item.symbol];
            if (clen > 32) clen = 32;
            if (clen != 0) begin
               // bits above the code length are masked off
               acc = ({57'd0, acc_bits} << clen)
                     | ({32'd0, sym_code[item.symbol]} & ((64'd1 << clen) - 64'd1));
               cnt = acc_count + clen;
               while (cnt >= 8) begin
                  cnt          = cnt - 8;
                  shifted      = acc >> cnt;
                  out.out_byte = shifted[7:0];
                  out.last     = (cnt < 8);   // final whole byte of this beat
                  expected_bytes.push_back(out);
               end
               acc       = acc & ((64'd1 << cnt) - 64'd1);
               acc_count = cnt[PEND_W-1:0];
               acc_bits  = acc[ACC_W-1:0];
            end
         end
         OP_FLUSH: begin
            // tail goes out right-aligned, no padding on the right
            if (acc_count != 0) begin
               out.out_byte = {1'b0, acc_bits & ((7'd1 << acc_count) - 7'd1)};
               out.last     = 1'b1;
               expected_bytes.push_back(out);
               acc_bits  = '0;
               acc_count = '0;
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Request driver: holds a stalled beat, otherwise may idle at random.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) pack_code_bytes(req_data);
         if (req_valid && req_stall) begin
            // stalled: keep beat unchanged
         end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: checks each taken beat, then picks the next stall.
   // ------------------------------------------------------------------
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected beat: out_byte 8'h%02h last %0b",
                      rsp_data.out_byte, rsp_data.last);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected 8'h%02h, actual 8'h%02h",
                         want.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus generation. Tracks which symbols have a code so that no
   // encode ever reads a never-loaded table entry.
   // ------------------------------------------------------------------
   bit        sym_loaded [256];
   logic [7:0] loaded_syms [$];

   function automatic req_type make_beat(logic [OP_W-1:0] op, logic [7:0] sym,
                                         logic [31:0] bits, logic [5:0] len);
      req_type b;
      b.operation   = op;
      b.symbol      = sym;
      b.code_bits   = bits;
      b.code_length = len;
      return b;
   endfunction

   task automatic add_load(input logic [7:0] sym, input logic [31:0] bits,
                           input logic [5:0] len);
      pending_items.push_back(make_beat(OP_LOAD, sym, bits, len));
      if (!sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   task automatic add_encode(input logic [7:0] sym);
      // unused fields carry noise; the block must ignore them
      pending_items.push_back(make_beat(OP_ENCODE, sym, $urandom, 6'($urandom)));
   endtask

   task automatic add_flush();
      pending_items.push_back(make_beat(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom)));
   endtask

   // Mostly well-formed traffic: loads, a run of encodes, occasional flush.
   task automatic add_random(input int unsigned count);
      int unsigned r;
      logic [5:0]  len;
      for (int unsigned i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 18 || loaded_syms.size() == 0) begin
            case ($urandom_range(9))
               0:       len = 6'($urandom_range(63, 33));   // overlong
               1:       len = 6'd0;
               2:       len = 6'd32;
               default: len = 6'($urandom_range(16, 1));
            endcase
            add_load(8'($urandom), $urandom, len);
         end else if (r < 80) begin
            add_encode(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
         end else if (r < 94) begin
            add_flush();
         end else begin
            // dropped op: does not count toward the item total
            pending_items.push_back(make_beat(OP_UNUSED, 8'($urandom), $urandom,
                                              6'($urandom)));
            i--;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      add_flush();                                  // nothing pending
      pending_items.push_back(make_beat(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
      add_load(8'd0,   32'hFFFF_FFFF, 6'd0);        // zero-length code
      add_load(8'd255, 32'hFFFF_FFFF, 6'd32);
      add_load(8'd1,   32'hFFFF_FFFF, 6'd1);        // bits above length ignored
      add_load(8'd2,   32'h0000_0055, 6'd7);
      add_load(8'd3,   32'h0000_00A5, 6'd8);
      add_load(8'd4,   32'h8000_0001, 6'd63);       // saturates to the cap
      add_load(8'd5,   32'h0000_0000, 6'd9);
      add_load(8'd128, 32'h1234_5678, 6'd33);       // just above the cap
      add_encode(8'd0);                             // appends nothing
      add_encode(8'd1);
      add_flush();                                  // single tail bit
      add_encode(8'd3);                             // exactly one byte
      add_encode(8'd2);                             // seven pending
      add_encode(8'd255);                           // four bytes out
      add_encode(8'd4);
      add_encode(8'd5);                             // lands on a byte boundary
      add_flush();                                  // nothing pending again
      add_encode(8'd2);
      add_flush();                                  // seven-bit tail
      add_encode(8'd128);
      add_flush();

      add_random(40);
      wait_idle();

      send_idle_pct = 72;
      recv_idle_pct = 37;
      add_random(40);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(40);
      add_flush();
      wait_idle();

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
